// ----- rtl/core/kf_pkg.sv -----
// Package for the scalar Kalman filter: field widths, register indexes and
// the request/response structs shared by the top level and the divider.
// No dependencies.
package kf_pkg;

	localparam int VAL_W    = 32;               // Q16.16 fields
	localparam int GAIN_W   = 17;               // Q1.16 gain, 65536 is one
	localparam int FRAC_W   = 16;               // fractional bits of the gain
	localparam int SUM_W    = VAL_W + 1;        // exact P + R, exact prediction
	localparam int DIFF_W   = VAL_W + 2;        // exact y - xp
	localparam int ACC_E_W  = DIFF_W + GAIN_W;  // signed diff * gain
	localparam int ACC_P_W  = VAL_W + GAIN_W;   // unsigned (1 - K) * P
	localparam int CFG_IDX_W = 1;

	localparam logic [GAIN_W-1:0] KF_ONE = GAIN_W'(1) << FRAC_W;

	localparam logic [CFG_IDX_W-1:0] REG_INIT_EST = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INIT_COV = CFG_IDX_W'(1);

	localparam logic [VAL_W-1:0] INIT_EST_RST = '0;
	localparam logic [VAL_W-1:0] INIT_COV_RST = VAL_W'(KF_ONE);

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] num;
		logic [SUM_W-1:0] den;
	} kf_div_req_t;

	typedef struct packed {
		logic              done;
		logic [GAIN_W-1:0] quot;
	} kf_div_rsp_t;

endpackage

// ----- rtl/core/kf_if.sv -----
// Valid/ready channel interfaces for the scalar Kalman filter.
// Depends on kf_pkg for field widths.
interface kf_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [kf_pkg::VAL_W-1:0]     process_increment;
	logic signed [kf_pkg::VAL_W-1:0]     sensor_value;
	logic        [kf_pkg::VAL_W-1:0]     sensor_variance;

	modport source (output valid, input ready,
		output process_increment, output sensor_value, output sensor_variance);
	modport sink (input valid, output ready,
		input process_increment, input sensor_value, input sensor_variance);
endinterface

interface kf_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [kf_pkg::VAL_W-1:0]     new_estimate;
	logic        [kf_pkg::GAIN_W-1:0]    kalman_gain;
	logic        [kf_pkg::VAL_W-1:0]     new_covariance;

	modport source (output valid, input ready,
		output new_estimate, output kalman_gain, output new_covariance);
	modport sink (input valid, output ready,
		input new_estimate, input kalman_gain, input new_covariance);
endinterface

// ----- rtl/core/kf_div.sv -----
// Bit-serial restoring divider for the gain P / (P + R) in Q1.16.
// Depends on kf_pkg. One quotient bit per cycle.
module kf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  kf_pkg::kf_div_req_t req,
	output kf_pkg::kf_div_rsp_t rsp
);
	import kf_pkg::*;

	typedef enum logic {D_IDLE, D_RUN} dstate_t;

	localparam int CNT_W = $clog2(FRAC_W);

	dstate_t            state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   den_q;
	logic [SUM_W-1:0]   rem_q;
	logic               q_hi_q;
	logic [FRAC_W-1:0]  q_lo_q;
	logic               zero_q;
	logic               done_q;

	logic [SUM_W:0]     shifted;
	logic               ge;
	logic               start_ge;

	assign shifted  = {rem_q, 1'b0};
	assign ge       = shifted >= {1'b0, den_q};
	// P never exceeds P + R, so the integer bit is set only when R is zero
	assign start_ge = {1'b0, req.num} >= req.den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			den_q   <= '0;
			rem_q   <= '0;
			q_hi_q  <= 1'b0;
			q_lo_q  <= '0;
			zero_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				D_IDLE: begin
					done_q <= 1'b0;
					if (req.start) begin
						den_q   <= req.den;
						zero_q  <= (req.den == '0);
						q_hi_q  <= start_ge;
						rem_q   <= start_ge ? SUM_W'({1'b0, req.num} - req.den)
						                    : {1'b0, req.num};
						q_lo_q  <= '0;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					// shift in one quotient bit, subtract when the divisor fits
					rem_q  <= SUM_W'(ge ? shifted - {1'b0, den_q} : shifted);
					q_lo_q <= {q_lo_q[FRAC_W-2:0], ge};
					cnt_q  <= cnt_q + CNT_W'(1);
					done_q <= (cnt_q == CNT_W'(FRAC_W - 1));
					if (cnt_q == CNT_W'(FRAC_W - 1)) begin
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = zero_q ? '0 : {q_hi_q, q_lo_q};

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> rsp.quot <= KF_ONE)
		else $error("divider quotient above one");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == D_RUN && !zero_q) |-> rem_q < den_q)
		else $error("divider remainder not below divisor");

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(state_q == D_RUN))
		else $error("divider done without a run");

endmodule

// ----- rtl/core/scalar_kalman_filter_top.sv -----
// Scalar Kalman filter, top level: control sequencer, bit-serial multipliers,
// state and output register. Depends on kf_pkg, kf_if and kf_div.
//
// One input transaction is one filter step and yields exactly one output
// transaction. From acceptance to the result appearing in the output
// register, a step runs through a setup state that forms y - xp and
// starts the divider, the 16-step restoring divider for the gain (one
// quotient bit a cycle) and the hand-back of the gain, the 17-step
// shift-add multipliers that walk the gain one bit a cycle (the estimate
// correction and the covariance update run side by side on the same step
// counter), and the commit that saturates and stores the result.
// The input is ready again the cycle after the commit, so steps do not
// overlap. The input is ready whenever no step is in flight, even while the
// last result still waits in the output register; a finished step holds in
// its last cycle only if the previous result has not been taken yet. Writing
// either configuration register reloads the estimate and covariance from both
// registers; write configuration only while the block is idle. Reset loads an
// estimate of 0 and a covariance of 1.0.
module scalar_kalman_filter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	kf_in_if.sink                          in_ch,
	kf_out_if.source                       out_ch,
	input  logic                           cfg_wr_en,
	input  logic [kf_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [kf_pkg::VAL_W-1:0]       cfg_data
);
	import kf_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_START, S_DIV, S_MUL} state_t;
	// S_MUL also covers the commit cycle, flagged by fin_q

	localparam int MCNT_W = $clog2(GAIN_W + 1);

	state_t                     state_q;
	logic                       fin_q;
	logic [MCNT_W-1:0]          cnt_q;

	logic [VAL_W-1:0]           init_est_q;
	logic [VAL_W-1:0]           init_cov_q;
	logic [VAL_W-1:0]           est_q;
	logic [VAL_W-1:0]           cov_q;

	logic signed [SUM_W-1:0]    xp_q;
	logic signed [VAL_W-1:0]    y_q;
	logic [SUM_W-1:0]           den_q;
	logic signed [DIFF_W-1:0]   diff_q;
	logic [GAIN_W-1:0]          k_q;
	logic [GAIN_W-1:0]          k_sh_q;
	logic [GAIN_W-1:0]          kc_sh_q;
	logic signed [ACC_E_W-1:0]  acc_e_q;
	logic [ACC_P_W-1:0]         acc_p_q;

	logic                       out_vld_q;
	logic [VAL_W-1:0]           out_est_q;
	logic [GAIN_W-1:0]          out_gain_q;
	logic [VAL_W-1:0]           out_cov_q;

	kf_div_req_t                div_req;
	kf_div_rsp_t                div_rsp;

	logic                       in_go;
	logic                       fin_go;
	logic                       out_free;
	logic signed [DIFF_W:0]     corr;
	logic signed [DIFF_W+1:0]   x_wide;
	logic [VAL_W-1:0]           x_sat;
	logic [VAL_W-1:0]           p_new;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_go       = in_ch.valid && in_ch.ready;
	assign out_free    = !out_vld_q || out_ch.ready;
	assign fin_go      = fin_q && out_free;

	// gain request: P over the exact sum P + R
	assign div_req.start = (state_q == S_START);
	assign div_req.num   = cov_q;
	assign div_req.den   = den_q;

	kf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// floor(K * (y - xp) / 65536) is the arithmetic shift of the product
	assign corr   = acc_e_q[ACC_E_W-1:FRAC_W];
	assign x_wide = {{3{xp_q[SUM_W-1]}}, xp_q} + {corr[DIFF_W], corr};

	// saturate to the signed 32-bit range
	always_comb begin
		if (x_wide[DIFF_W+1:VAL_W-1] == '0 || x_wide[DIFF_W+1:VAL_W-1] == '1) begin
			x_sat = x_wide[VAL_W-1:0];
		end else if (x_wide[DIFF_W+1]) begin
			x_sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			x_sat = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	// (1 - K) * P never exceeds P * 65536, so the upper bits drop cleanly
	assign p_new = acc_p_q[FRAC_W+VAL_W-1:FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fin_q      <= 1'b0;
			cnt_q      <= '0;
			init_est_q <= INIT_EST_RST;
			init_cov_q <= INIT_COV_RST;
			est_q      <= INIT_EST_RST;
			cov_q      <= INIT_COV_RST;
			xp_q       <= '0;
			y_q        <= '0;
			den_q      <= '0;
			diff_q     <= '0;
			k_q        <= '0;
			k_sh_q     <= '0;
			kc_sh_q    <= '0;
			acc_e_q    <= '0;
			acc_p_q    <= '0;
			out_vld_q  <= 1'b0;
			out_est_q  <= '0;
			out_gain_q <= '0;
			out_cov_q  <= '0;
		end else begin
			// drop the result once the sink takes it, unless a new one lands
			if (out_ch.ready && !fin_go) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_go) begin
						// predict: exact 33-bit estimate, exact 33-bit denominator
						xp_q    <= $signed({est_q[VAL_W-1], est_q})
						         + $signed({in_ch.process_increment[VAL_W-1],
						                    in_ch.process_increment});
						y_q     <= in_ch.sensor_value;
						den_q   <= {1'b0, cov_q} + {1'b0, in_ch.sensor_variance};
						state_q <= S_START;
					end
				end
				S_START: begin
					diff_q  <= $signed({{2{y_q[VAL_W-1]}}, y_q})
					         - $signed({xp_q[SUM_W-1], xp_q});
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						k_q     <= div_rsp.quot;
						k_sh_q  <= div_rsp.quot;
						kc_sh_q <= KF_ONE - div_rsp.quot;
						acc_e_q <= '0;
						acc_p_q <= '0;
						cnt_q   <= '0;
						fin_q   <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (!fin_q) begin
						// advance both products by one gain bit, most significant first
						acc_e_q <= {acc_e_q[ACC_E_W-2:0], 1'b0}
						         + (k_sh_q[GAIN_W-1] ? ACC_E_W'(diff_q) : '0);
						acc_p_q <= {acc_p_q[ACC_P_W-2:0], 1'b0}
						         + (kc_sh_q[GAIN_W-1] ? ACC_P_W'(cov_q) : '0);
						k_sh_q  <= {k_sh_q[GAIN_W-2:0], 1'b0};
						kc_sh_q <= {kc_sh_q[GAIN_W-2:0], 1'b0};
						cnt_q   <= cnt_q + MCNT_W'(1);
						if (cnt_q == MCNT_W'(GAIN_W - 1)) begin
							fin_q <= 1'b1;
						end
					end else if (out_free) begin
						// commit the step: update state and load the output register
						est_q      <= x_sat;
						cov_q      <= p_new;
						out_vld_q  <= 1'b1;
						out_est_q  <= x_sat;
						out_gain_q <= k_q;
						out_cov_q  <= p_new;
						fin_q      <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// a write to either register reloads both state entries
			if (cfg_wr_en) begin
				case (cfg_idx)
					REG_INIT_EST: begin
						init_est_q <= cfg_data;
						est_q      <= cfg_data;
						cov_q      <= init_cov_q;
					end
					REG_INIT_COV: begin
						init_cov_q <= cfg_data;
						est_q      <= init_est_q;
						cov_q      <= cfg_data;
					end
					default: ;
				endcase
			end
		end
	end

	assign out_ch.valid          = out_vld_q;
	assign out_ch.new_estimate   = out_est_q;
	assign out_ch.kalman_gain    = out_gain_q;
	assign out_ch.new_covariance = out_cov_q;

	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(fin_go))
		else $error("result appeared without a committed step");

	a_cov_no_growth: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && !cfg_wr_en) |=> cov_q <= $past(cov_q))
		else $error("covariance grew in an update");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ch.ready) |=> out_vld_q && $stable(out_gain_q))
		else $error("pending result overwritten");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> k_q <= KF_ONE)
		else $error("gain above one");

endmodule
